FILE: src/pctd_pkg.sv
// Shared types, constants and the hex digit helper for the percent escape decoder.
package pctd_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    // Most result words one input word can produce
    localparam int RES_MAX  = 3;
    // Result queue depth, index width and count width
    localparam int QDEPTH   = 4;
    localparam int QIDX_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_DIG  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef t_result [RES_MAX-1:0] t_res_vec;

    // Hex digit value with a valid flag
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            h.val = c[3:0];
        end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
            // 'A'..'F' and 'a'..'f' have low bits 1..6
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: src/pctd_decode.sv
// Next-state and result logic for one input word of the escape decoder.
module pctd_decode (
    input  pctd_pkg::t_phase   i_phase,
    input  logic [7:0]         i_held,
    input  logic [7:0]         i_data,
    input  logic               i_last,
    output pctd_pkg::t_phase   o_phase,
    output logic [7:0]         o_held,
    output logic [1:0]         o_num,
    output pctd_pkg::t_res_vec o_res
);
    import pctd_pkg::*;

    t_hex       h1;
    t_hex       h2;
    logic [7:0] dec_val;

    assign h1      = hex_value(i_held);
    assign h2      = hex_value(i_data);
    assign dec_val = {h1.val, h2.val};

    // Results are packed from slot 0 upward
    always_comb begin
        o_phase = i_phase;
        o_held  = i_held;
        o_num   = 2'd0;
        o_res   = '0;
        unique case (i_phase)
            PH_PCT: begin
                if (i_last) begin
                    o_res[0] = '{data: CH_PCT, last: 1'b0};
                    o_res[1] = '{data: i_data, last: 1'b1};
                    o_num    = 2'd2;
                    o_phase  = PH_IDLE;
                end else begin
                    o_held  = i_data;
                    o_phase = PH_DIG;
                end
            end
            PH_DIG: begin
                if (h1.ok && h2.ok && dec_val != 8'd0) begin
                    o_res[0] = '{data: dec_val, last: i_last};
                    o_num    = 2'd1;
                    o_phase  = PH_IDLE;
                end else begin
                    o_res[0] = '{data: CH_PCT, last: 1'b0};
                    if (i_held == CH_PCT) begin
                        // held percent opens a new escape
                        if (i_last) begin
                            o_res[1] = '{data: CH_PCT, last: 1'b0};
                            o_res[2] = '{data: i_data, last: 1'b1};
                            o_num    = 2'd3;
                            o_phase  = PH_IDLE;
                        end else begin
                            o_num   = 2'd1;
                            o_held  = i_data;
                            o_phase = PH_DIG;
                        end
                    end else begin
                        o_res[1] = '{data: i_held, last: 1'b0};
                        if (i_data == CH_PCT && !i_last) begin
                            o_num   = 2'd2;
                            o_phase = PH_PCT;
                        end else begin
                            o_res[2] = '{data: i_data, last: i_last};
                            o_num    = 2'd3;
                            o_phase  = PH_IDLE;
                        end
                    end
                end
            end
            default: begin
                // idle, and the unused code acts as idle
                if (i_data == CH_PCT && !i_last) begin
                    o_phase = PH_PCT;
                end else begin
                    o_res[0] = '{data: i_data, last: i_last};
                    o_num    = 2'd1;
                    o_phase  = PH_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: src/pctd_outq.sv
// Result queue: takes up to three words at once, hands out one word per cycle while i_stall is low.
module pctd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [1:0]         i_num,
    input  pctd_pkg::t_res_vec i_res,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [7:0]         o_data,
    output logic               o_last,
    output logic               o_room
);
    import pctd_pkg::*;

    t_result                r_mem [QDEPTH];
    logic [QIDX_W-1:0]      r_rd;
    logic [QIDX_W-1:0]      n_rd;
    logic [QCNT_W-1:0]      r_count;
    logic [QCNT_W-1:0]      n_count;
    logic [QIDX_W-1:0]      wr_base;
    logic [QCNT_W-1:0]      push_n;
    logic                   pop;
    logic [QCNT_W-1:0]      after_pop;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd].data;
    assign o_last    = r_mem[r_rd].last;
    assign pop       = o_valid && !i_stall;
    assign after_pop = r_count - QCNT_W'(pop);
    // room for a full burst once this cycle's pop is done
    assign o_room    = (after_pop <= QCNT_W'(QDEPTH - RES_MAX));
    assign push_n    = i_push ? QCNT_W'(i_num) : '0;
    assign wr_base   = r_rd + r_count[QIDX_W-1:0];

    // pointer and fill count
    always_comb begin
        n_rd    = r_rd + QIDX_W'(pop);
        n_count = after_pop + push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // burst write of the new results
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (i_push && (2'(k) < i_num)) begin
                r_mem[wr_base + QIDX_W'(k)] <= i_res[k];
            end
        end
    end

endmodule

FILE: src/percent_escape_decoder.sv
// Top level of the percent escape decoder: escape state plus result queue.
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_in_byte, i_in_last
//  output    out        o_valid / i_stall  o_out_byte, o_out_last
//
// One input word is taken per cycle while o_stall is low; its results go to a
// four-entry queue that hands out one word per cycle while i_stall is low.
// A word giving three results can hold o_stall high while they drain.
// o_stall is high whenever the queue could not take a full burst of three.
// Synchronous active-low reset empties the queue and clears the escape state.
module percent_escape_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import pctd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic [1:0] res_num;
    t_res_vec   res;
    logic       room;
    logic       accept;

    assign o_stall = !room;
    assign accept  = i_valid && room;

    // per-word decode
    pctd_decode u_decode (
        .i_phase (r_phase),
        .i_held  (r_held),
        .i_data  (i_in_byte),
        .i_last  (i_in_last),
        .o_phase (n_phase),
        .o_held  (n_held),
        .o_num   (res_num),
        .o_res   (res)
    );

    // escape state advances on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // result queue
    pctd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_num   (res_num),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_out_byte),
        .o_last  (o_out_last),
        .o_room  (room)
    );

endmodule

FILE: tb/percent_escape_decoder_tb.sv
// Self-checking testbench for the percent escape decoder: directed and random strings.
module percent_escape_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pctd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    percent_escape_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    t_in_word pending_in[$];
    t_result  expected_out[$];

    // Escape tracking state of the predictor
    t_phase     esc_phase = PH_IDLE;
    logic [7:0] esc_held  = 8'h00;

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  words_checked  = 0;
    int  strings_sent   = 0;
    int  escapes_done   = 0;
    int  escapes_kept   = 0;
    logic in_taken      = 1'b0;
    int  tx_gap = 0, rx_gap = 0;
    int  tx_cycle = 0, rx_cycle = 0;
    logic tx_quiet = 1'b0, rx_quiet = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hex digit value, -1 when the byte is not a hex digit
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void expect_word(input logic [7:0] b, input logic last);
        t_result r;
        r.data = b;
        r.last = last;
        expected_out = {expected_out, r};
    endfunction

    // Byte seen with no escape open
    function automatic void take_plain(input logic [7:0] b, input logic last);
        if (b == CH_PCT && !last) begin
            esc_phase = PH_PCT;
        end else begin
            expect_word(b, last);
            esc_phase = PH_IDLE;
        end
    endfunction

    // Advance the decoder state by one accepted word and queue its decoded bytes
    function automatic void decode_word(input logic [7:0] b, input logic last);
        int d1, d2;
        logic [7:0] v;
        case (esc_phase)
            PH_PCT: begin
                if (last) begin
                    expect_word(CH_PCT, 1'b0);
                    expect_word(b, 1'b1);
                    esc_phase = PH_IDLE;
                end else begin
                    esc_held  = b;
                    esc_phase = PH_DIG;
                end
            end
            PH_DIG: begin
                d1 = hex_digit(esc_held);
                d2 = hex_digit(b);
                v  = (d1 >= 0 && d2 >= 0) ? 8'((d1 << 4) | d2) : 8'h00;
                if (v != 8'h00) begin
                    expect_word(v, last);
                    esc_phase = PH_IDLE;
                    escapes_done++;
                end else begin
                    escapes_kept++;
                    expect_word(CH_PCT, 1'b0);
                    if (esc_held == CH_PCT) begin
                        // held percent opens a fresh escape with b as first digit
                        if (last) begin
                            expect_word(CH_PCT, 1'b0);
                            expect_word(b, 1'b1);
                            esc_phase = PH_IDLE;
                        end else begin
                            esc_held = b;
                        end
                    end else begin
                        expect_word(esc_held, 1'b0);
                        take_plain(b, last);
                    end
                end
            end
            default: take_plain(b, last);
        endcase
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_char();
        int k;
        k = $urandom_range(0, 21);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CH_PCT;
            4, 5, 6, 7: begin
                if (k < 10) return CH_0 + 8'(k);
                if (k < 16) return CH_UA + 8'(k - 10);
                return CH_LA + 8'(k - 16);
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last);
        t_in_word w;
        w.data = b;
        w.last = last;
        pending_in = {pending_in, w};
        if (last) strings_sent++;
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
    endfunction

    // Input side: hold each word until accepted, with random gaps
    always @(negedge i_clk) begin : tx_drive
        t_in_word w;
        tx_cycle <= tx_cycle + 1;
        if (tx_cycle % 64 == 63) tx_quiet <= ($urandom_range(0, 3) == 0);
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap  <= tx_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_in.size() > 0) begin
                w = pending_in.pop_front();
                i_in_byte <= w.data;
                i_in_last <= w.last;
                i_valid   <= 1'b1;
                tx_gap    <= pick_gap(tx_quiet);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output side: random stall
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 31) rx_quiet <= ($urandom_range(0, 3) == 0);
        if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            i_stall <= 1'b1;
        end else begin
            rx_gap  <= pick_gap(rx_quiet);
            i_stall <= 1'b0;
        end
    end

    // Sample both handshakes; check results, then predict from the accepted word
    always @(posedge i_clk) begin : watch
        t_result r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %02h last %0b",
                         $time, o_out_byte, o_out_last);
                mismatch_count++;
            end else begin
                r = expected_out.pop_front();
                words_checked++;
                if (o_out_byte !== r.data) begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, r.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_out_last !== r.last) begin
                    $display("%0t: out_last mismatch, expected %0b, got %0b",
                             $time, r.last, o_out_last);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            in_taken <= 1'b1;
            words_sent++;
            decode_word(i_in_byte, i_in_last);
        end else begin
            in_taken <= 1'b0;
        end
    end

    initial begin
        int len;
        // Directed strings: byte extremes, good, zero and malformed escapes, short tails
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_str("%41");
        push_str("%fF");
        push_str("%00");
        push_str("%G1x");
        push_str("%%4a");
        push_str("%%4");
        push_str("%");
        push_str("%4");
        // Random strings, escape heavy
        while (pending_in.size() < 300) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) push_byte(rand_char(), i == len - 1);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_in.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d words in %0d strings; %0d escapes decoded, %0d kept as text.",
                 words_sent, strings_sent, escapes_done, escapes_kept);
        $display("Checked %0d decoded words under random gaps and stalls.", words_checked);
        if (mismatch_count == 0 && expected_out.size() == 0) begin
            $display("percent_escape_decoder_tb: clean");
        end else begin
            $display("percent_escape_decoder_tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("Timeout with %0d words still expected.", expected_out.size());
        $display("percent_escape_decoder_tb: errors");
        $finish;
    end

endmodule

FILE: files.f
src/pctd_pkg.sv
src/pctd_decode.sv
src/pctd_outq.sv
src/percent_escape_decoder.sv
tb/percent_escape_decoder_tb.sv
